[design/modbus_rtu_request_framer_unit_defines.svh]
// assertion macros shared by the framer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef MODBUS_RTU_REQUEST_FRAMER_UNIT_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define MRRF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MRRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mrrf_pkg.sv]
// types, constants and the crc step for the modbus rtu request framer
// no dependencies
package mrrf_pkg;

    localparam int MAX_REGS   = 123;
    localparam int READ_MAX   = 125;
    localparam int IN_DATA_W  = 40;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;
    localparam int LEFT_W     = 8;
    localparam int IDX_W      = 3;

    localparam logic [7:0]  FN_READ  = 8'h03;
    localparam logic [7:0]  FN_WRITE = 8'h10;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ       = 2'd0,
        KIND_WRITE_HDR  = 2'd1,
        KIND_WRITE_DATA = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK           = 2'd0,
        STAT_BAD_COUNT    = 2'd1,
        STAT_OUT_OF_PHASE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MODE_STATUS = 2'd0,
        MODE_READ   = 2'd1,
        MODE_HDR    = 2'd2,
        MODE_DATA   = 2'd3
    } mode_t;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[design/modbus_rtu_request_framer_unit.sv]
// modbus rtu request framer: items in, frame bytes with crc out
// depends on mrrf_pkg
//
// usage
// - input channel s_*: one request word per handshake. s_tuser is the kind
//   (read request, write header, write data byte), s_tdata the other fields.
// - output channel m_*: one frame byte per word, tlast on the final crc byte,
//   tuser carries the status; a status word has tdata zero.
// - a read request gives 8 bytes, a write header 7, a data byte 1 (3 for the
//   last one of the payload, which adds the crc), an error a single word.
// - the work register emits one byte per cycle into the output register while
//   the output is not stalled; the next item is taken in the cycle its
//   predecessor's last byte leaves, so items run back to back.
// - an accepted item is registered in the work register, and its bytes then pass to the output register.
// - the crc advances one byte per cycle alongside the emitted header and data bytes while the output is not stalled.
// - when m_tready is low the output word holds, the work register stalls and
//   s_tready drops once the current item cannot finish.
// - reset clears the pending write phase and sets the running crc to all ones.
module modbus_rtu_request_framer_unit
    import mrrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [7:0] slave_address, [23:8] register_address, [30:24] register_count,
    // [38:31] data_byte, [39] zero
    input  logic [IN_DATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]    s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] out_byte
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    // [1:0] status
    output logic [STATUS_W-1:0]  m_tuser
);

    // input fields
    logic [7:0]         in_addr;
    logic [15:0]        in_reg;
    logic [COUNT_W-1:0] in_count;
    logic [7:0]         in_data;

    assign in_addr  = s_tdata[7:0];
    assign in_reg   = s_tdata[23:8];
    assign in_count = s_tdata[30:24];
    assign in_data  = s_tdata[38:31];

    // state
    logic [LEFT_W-1:0]  payload_left_reg, payload_left_next;
    logic [15:0]        crc_reg, crc_next;

    // work register
    logic               work_valid_reg;
    mode_t              mode_reg;
    status_t            status_reg;
    logic               finish_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [7:0]         addr_reg;
    logic [15:0]        regno_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         data_reg;

    // output register
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic               m_tlast_reg;
    status_t            m_tuser_reg;

    // load decode
    mode_t              ld_mode;
    status_t            ld_status;
    logic               ld_finish;
    logic               count_ok;

    // emission
    logic [7:0]         emit_byte;
    logic               emit_last;
    logic               emit_feed;
    logic               emit_clear;
    logic [IDX_W-1:0]   last_idx;
    logic               emit_ready;
    logic               emit_fire;
    logic               item_done;
    logic               in_fire;

    assign emit_ready = !m_tvalid_reg || m_tready;
    assign emit_fire  = work_valid_reg && emit_ready;
    assign item_done  = emit_fire && (idx_reg == last_idx);
    assign s_tready   = !work_valid_reg || item_done;
    assign in_fire    = s_tvalid && s_tready;

    // classify an incoming item against the pending write phase
    always_comb
    begin
        ld_mode           = MODE_STATUS;
        ld_status         = STAT_OUT_OF_PHASE;
        ld_finish         = 1'b0;
        payload_left_next = payload_left_reg;
        count_ok          = 1'b0;
        unique case (s_tuser) inside
            KIND_WRITE_DATA:
            begin
                if (payload_left_reg != '0)
                begin
                    ld_mode           = MODE_DATA;
                    ld_status         = STAT_OK;
                    ld_finish         = (payload_left_reg == LEFT_W'(1));
                    payload_left_next = payload_left_reg - LEFT_W'(1);
                end
            end
            KIND_READ, KIND_WRITE_HDR:
            begin
                if (s_tuser == KIND_READ)
                    count_ok = (in_count != '0) && (in_count <= COUNT_W'(READ_MAX));
                else
                    count_ok = (in_count != '0) && (in_count <= COUNT_W'(MAX_REGS));
                if (payload_left_reg != '0)
                    ld_status = STAT_OUT_OF_PHASE;
                else if (!count_ok)
                    ld_status = STAT_BAD_COUNT;
                else
                begin
                    ld_status = STAT_OK;
                    if (s_tuser == KIND_READ)
                        ld_mode = MODE_READ;
                    else
                    begin
                        ld_mode           = MODE_HDR;
                        payload_left_next = {in_count, 1'b0};
                    end
                end
            end
            default:
            begin
                ld_status = STAT_OUT_OF_PHASE;
            end
        endcase
    end

    // byte select for the current item and position
    always_comb
    begin
        emit_byte  = 8'h00;
        emit_last  = 1'b0;
        emit_feed  = 1'b0;
        emit_clear = 1'b0;
        last_idx   = '0;
        unique case (mode_reg) inside
            MODE_READ, MODE_HDR:
            begin
                last_idx  = (mode_reg == MODE_READ) ? IDX_W'(7) : IDX_W'(6);
                emit_feed = (idx_reg <= IDX_W'(5)) || (mode_reg == MODE_HDR);
                case (idx_reg)
                    3'd0: emit_byte = addr_reg;
                    3'd1: emit_byte = (mode_reg == MODE_READ) ? FN_READ : FN_WRITE;
                    3'd2: emit_byte = regno_reg[15:8];
                    3'd3: emit_byte = regno_reg[7:0];
                    3'd4: emit_byte = 8'h00;
                    3'd5: emit_byte = {1'b0, count_reg};
                    3'd6: emit_byte = (mode_reg == MODE_READ) ? crc_reg[7:0]
                                                              : {count_reg, 1'b0};
                    default:
                    begin
                        emit_byte  = crc_reg[15:8];
                        emit_last  = 1'b1;
                        emit_clear = 1'b1;
                    end
                endcase
            end
            MODE_DATA:
            begin
                last_idx = finish_reg ? IDX_W'(2) : IDX_W'(0);
                case (idx_reg)
                    3'd0:
                    begin
                        emit_byte = data_reg;
                        emit_feed = 1'b1;
                    end
                    3'd1: emit_byte = crc_reg[7:0];
                    default:
                    begin
                        emit_byte  = crc_reg[15:8];
                        emit_last  = 1'b1;
                        emit_clear = 1'b1;
                    end
                endcase
            end
            default:
            begin
                last_idx = '0;
            end
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (emit_fire && emit_feed)
            crc_next = crc_byte(crc_reg, emit_byte);
        else if (emit_fire && emit_clear)
            crc_next = CRC_INIT;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_left_reg <= '0;
            crc_reg          <= CRC_INIT;
            work_valid_reg   <= 1'b0;
            idx_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            crc_reg <= crc_next;
            if (in_fire)
                payload_left_reg <= payload_left_next;

            if (in_fire)
            begin
                work_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (item_done)
                work_valid_reg <= 1'b0;
            else if (emit_fire)
                idx_reg <= idx_reg + IDX_W'(1);

            if (emit_fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg   <= ld_mode;
            status_reg <= ld_status;
            finish_reg <= ld_finish;
            addr_reg   <= in_addr;
            regno_reg  <= in_reg;
            count_reg  <= in_count;
            data_reg   <= in_data;
        end
        if (emit_fire)
        begin
            m_tdata_reg <= emit_byte;
            m_tlast_reg <= emit_last;
            m_tuser_reg <= (mode_reg == MODE_STATUS) ? status_reg : STAT_OK;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[design/mrrf_checker.sv]
// port-level checks for the modbus rtu request framer, bound to the top level
// depends on mrrf_pkg and modbus_rtu_request_framer_unit_defines.svh
`include "modbus_rtu_request_framer_unit_defines.svh"

module mrrf_checker
    import mrrf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [IN_DATA_W-1:0] s_tdata,
    input logic [KIND_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [7:0]           m_tdata,
    input logic                 m_tlast,
    input logic [STATUS_W-1:0]  m_tuser
);

    // a stalled output word holds
    `MRRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output word changed while stalled")

    // error words carry no byte
    `MRRF_ASSERT_SAME(a_status_zero, m_tvalid && (m_tuser != STAT_OK), m_tdata == 8'h00, "error word with nonzero byte")

    // frame end only on a good crc byte
    `MRRF_ASSERT_SAME(a_last_ok, m_tvalid && m_tlast, m_tuser == STAT_OK, "tlast on an error word")

endmodule

bind modbus_rtu_request_framer_unit mrrf_checker u_mrrf_checker (.*);

[sim/modbus_rtu_request_framer_unit_checker.sv]
// frame predictor and output compare for modbus_rtu_request_framer_unit
// depends on mrrf_pkg; watches both stream channels of the block
`timescale 1ns / 100ps
module modbus_rtu_request_framer_unit_checker
    import mrrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [7:0] slave_address, [23:8] register_address, [30:24] register_count,
    // [38:31] data_byte, [39] zero
    input  logic [IN_DATA_W-1:0] s_tdata,
    // [1:0] kind
    input  logic [KIND_W-1:0]    s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] out_byte
    input  logic [7:0]           m_tdata,
    input  logic                 m_tlast,
    // [1:0] status
    input  logic [STATUS_W-1:0]  m_tuser,
    output int                   fail_count,
    output int                   words_due
);

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        status_t    stat;
    } frame_word_t;

    frame_word_t frame_q[$];
    logic [15:0] write_crc;
    logic [7:0]  write_left;
    int          mismatch_total;

    assign fail_count = mismatch_total;

    // crc-16/modbus, feedback taken bit by bit from the lsb
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void push_word(input logic [7:0] value, input logic last,
                                      input status_t stat);
        frame_word_t w;
        w.value = value;
        w.last  = last;
        w.stat  = stat;
        frame_q.push_back(w);
    endfunction

    // bytes that one request word should produce
    function automatic void frame_request(input logic [KIND_W-1:0] kind,
                                          input logic [IN_DATA_W-1:0] word);
        logic [7:0]  addr;
        logic [7:0]  data;
        logic [15:0] reg_addr;
        logic [6:0]  count;
        logic [7:0]  hdr [7];
        logic [15:0] crc;
        int          n;
        int          i;
        addr     = word[7:0];
        reg_addr = word[23:8];
        count    = word[30:24];
        data     = word[38:31];
        if (kind == KIND_UNUSED)
            push_word(8'h00, 1'b0, STAT_OUT_OF_PHASE);
        else if (kind == KIND_WRITE_DATA)
        begin
            if (write_left == 8'd0)
                push_word(8'h00, 1'b0, STAT_OUT_OF_PHASE);
            else
            begin
                write_crc  = crc16_update(write_crc, data);
                write_left = write_left - 8'd1;
                push_word(data, 1'b0, STAT_OK);
                if (write_left == 8'd0)
                begin
                    push_word(write_crc[7:0], 1'b0, STAT_OK);
                    push_word(write_crc[15:8], 1'b1, STAT_OK);
                    write_crc = CRC_INIT;
                end
            end
        end
        else if (write_left != 8'd0)
            push_word(8'h00, 1'b0, STAT_OUT_OF_PHASE);
        else if (count == 7'd0 || count > ((kind == KIND_READ) ? READ_MAX : MAX_REGS))
            push_word(8'h00, 1'b0, STAT_BAD_COUNT);
        else
        begin
            hdr[0] = addr;
            hdr[1] = (kind == KIND_READ) ? FN_READ : FN_WRITE;
            hdr[2] = reg_addr[15:8];
            hdr[3] = reg_addr[7:0];
            hdr[4] = 8'h00;
            hdr[5] = {1'b0, count};
            hdr[6] = {count, 1'b0};
            n   = (kind == KIND_READ) ? 6 : 7;
            crc = CRC_INIT;
            for (i = 0; i < n; i++)
            begin
                crc = crc16_update(crc, hdr[i]);
                push_word(hdr[i], 1'b0, STAT_OK);
            end
            if (kind == KIND_READ)
            begin
                push_word(crc[7:0], 1'b0, STAT_OK);
                push_word(crc[15:8], 1'b1, STAT_OK);
            end
            else
            begin
                write_crc  = crc;
                write_left = hdr[6];
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_word_t w;
        if (!rst_n)
        begin
            frame_q.delete();
            write_crc      = CRC_INIT;
            write_left     = 8'd0;
            mismatch_total = 0;
            words_due     <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_q.size() == 0)
                begin
                    $error("unexpected word: out_byte %0h last_byte %0b status %0d",
                           m_tdata, m_tlast, m_tuser);
                    mismatch_total++;
                end
                else
                begin
                    w = frame_q.pop_front();
                    if (m_tdata !== w.value)
                    begin
                        $error("out_byte: expected %0h, actual %0h", w.value, m_tdata);
                        mismatch_total++;
                    end
                    if (m_tlast !== w.last)
                    begin
                        $error("last_byte: expected %0b, actual %0b", w.last, m_tlast);
                        mismatch_total++;
                    end
                    if (m_tuser !== w.stat)
                    begin
                        $error("status: expected %0d, actual %0d", w.stat, m_tuser);
                        mismatch_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                frame_request(s_tuser, s_tdata);
            words_due <= frame_q.size();
        end
    end

endmodule

[sim/modbus_rtu_request_framer_unit_tb.sv]
// stimulus and verdict for modbus_rtu_request_framer_unit
// depends on mrrf_pkg, the block and modbus_rtu_request_framer_unit_checker
`timescale 1ns / 100ps
module modbus_rtu_request_framer_unit_tb;
    import mrrf_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int HOLD_CYCLES  = 150;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 110;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_style_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic [STATUS_W-1:0]  m_tuser;

    int fail_count;
    int words_due;
    int items_sent;
    int burst_left;
    bit hold_req;

    modbus_rtu_request_framer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    modbus_rtu_request_framer_unit_checker frame_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // after each accepted word either keep going or drop valid for a gap
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap        = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 12);
            s_tvalid <= 1'b0;
            s_tdata  <= {8'($urandom), 32'($urandom)};
            s_tuser  <= 2'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_item(input logic [KIND_W-1:0] kind, input logic [7:0] addr,
                            input logic [15:0] reg_addr, input logic [6:0] count,
                            input logic [7:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, data, count, reg_addr, addr};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        pace_sender();
    endtask

    // fields that the kind ignores carry random values
    task automatic put_request(input logic [KIND_W-1:0] kind, input logic [6:0] count);
        put_item(kind, 8'($urandom), 16'($urandom), count, 8'($urandom));
    endtask

    task automatic put_data(input logic [7:0] data);
        put_item(KIND_WRITE_DATA, 8'($urandom), 16'($urandom), 7'($urandom), data);
    endtask

    task automatic put_misplaced();
        int pick;
        pick = $urandom_range(0, 2);
        put_request((pick == 0) ? KIND_READ : (pick == 1) ? KIND_WRITE_HDR : KIND_UNUSED,
                    7'($urandom));
    endtask

    task automatic write_frame(input int count, input bit noisy);
        int i;
        put_request(KIND_WRITE_HDR, 7'(count));
        for (i = 0; i < 2 * count; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
                put_misplaced();
            put_data(8'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_due != 0);
    endtask

    task automatic put_noise();
        case ($urandom_range(0, 4))
            0: put_data(8'($urandom));
            1: put_request(KIND_UNUSED, 7'($urandom));
            2: put_request(KIND_READ, ($urandom_range(0, 1) == 0) ? 7'd0
                                      : 7'($urandom_range(READ_MAX + 1, 127)));
            3: put_request(KIND_WRITE_HDR, ($urandom_range(0, 1) == 0) ? 7'd0
                                           : 7'($urandom_range(MAX_REGS + 1, 127)));
            default: put_request(KIND_WRITE_HDR, 7'($urandom_range(1, 3)));
        endcase
    endtask

    // receiver: changes its stall style now and then, long hold-off on request
    initial
    begin
        rx_style_t style;
        int        style_left;
        int        tick;
        m_tready   = 1'b0;
        style      = RX_OPEN;
        style_left = 0;
        tick       = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(50, 300);
                end
                style_left--;
                tick++;
                case (style)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_COIN:    m_tready <= 1'($urandom);
                    RX_PATTERN: m_tready <= (tick % 5) < 3;
                    default:    m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int  random_end;
        int  r;
        bit  pressure_done;
        bit  pause_done;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = KIND_READ;
        hold_req      = 1'b0;
        items_sent    = 0;
        burst_left    = 0;
        pressure_done = 1'b0;
        pause_done    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, bad counts and misplaced words
        put_item(KIND_READ, 8'h00, 16'h0000, 7'd1, 8'h00);
        put_item(KIND_READ, 8'hFF, 16'hFFFF, 7'(READ_MAX), 8'hFF);
        put_request(KIND_READ, 7'd0);
        put_request(KIND_READ, 7'(READ_MAX + 1));
        put_request(KIND_READ, 7'd127);
        put_data(8'hFF);
        put_request(KIND_UNUSED, 7'd127);
        put_request(KIND_WRITE_HDR, 7'd0);
        put_request(KIND_WRITE_HDR, 7'(MAX_REGS + 1));
        put_request(KIND_WRITE_HDR, 7'd127);
        put_item(KIND_WRITE_HDR, 8'hFF, 16'hFFFF, 7'd1, 8'hFF);
        // write pending: requests are out of phase, payload continues after them
        put_request(KIND_READ, 7'd5);
        put_request(KIND_WRITE_HDR, 7'd5);
        put_request(KIND_UNUSED, 7'd5);
        put_data(8'h00);
        put_data(8'hFF);
        put_item(KIND_WRITE_HDR, 8'h00, 16'h0000, 7'd2, 8'h00);
        put_data(8'hA5);
        put_data(8'h5A);
        put_data(8'hFF);
        put_data(8'h00);
        put_data(8'h3C);

        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end)
        begin
            if (!pressure_done && items_sent > random_end - 80)
            begin
                // output held off while words keep coming back to back
                pressure_done = 1'b1;
                hold_req      = 1'b1;
                burst_left    = 60;
                write_frame(20, 1'b0);
            end
            else if (!pause_done && items_sent > random_end - 40)
            begin
                pause_done = 1'b1;
                drain();
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    put_request(KIND_READ, 7'($urandom_range(1, READ_MAX)));
                else if (r < 75)
                    write_frame(($urandom_range(0, 5) == 0) ? $urandom_range(1, 12)
                                                            : $urandom_range(1, 3),
                                $urandom_range(0, 2) == 0);
                else
                    put_noise();
            end
        end

        // fresh reset, then the largest write header and the start of its payload
        drain();
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        put_request(KIND_WRITE_HDR, 7'(MAX_REGS));
        repeat (8) put_data(8'($urandom));

        drain();
        repeat (12) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
